// File: rtl/rcsl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rcsl_pkg;

   // Widths of the register port and of the fixed payload fields.
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;
   localparam int CHAN_BITS      = 4;
   localparam int HITS_BITS      = 8;
   localparam int COUNT_BITS     = 32;
   localparam int NOW_BITS       = 32;
   localparam int MS_BITS        = 16;

   // The receive rate is refreshed once per window of this many milliseconds.
   localparam int RATE_WINDOW_MS = 1000;

   // The per-channel valid packet count saturates here.
   localparam logic [HITS_BITS-1:0] HITS_MAX = '1;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCAN_ENABLE    = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CHAN_MIN       = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CHAN_MAX       = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LOCK_THRESHOLD = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DWELL_MS       = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LOST_MS        = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STALE_MS       = 3'd6;

   // Event codes carried in req_type; the fourth code is unused.
   typedef enum logic [1:0] {
      EVT_START  = 2'd0,
      EVT_PACKET = 2'd1,
      EVT_TICK   = 2'd2
   } evt_code_type;

   // Configuration register contents.
   typedef struct packed {
      logic                 scan_enable;
      logic [CHAN_BITS-1:0] chan_min;
      logic [CHAN_BITS-1:0] chan_max;
      logic [HITS_BITS-1:0] lock_threshold;
      logic [MS_BITS-1:0]   dwell_ms;
      logic [MS_BITS-1:0]   lost_ms;
      logic [MS_BITS-1:0]   stale_ms;
   } cfg_type;

   // One accepted event.
   typedef struct packed {
      logic [1:0]          req_type;
      logic                packet_ok;
      logic [NOW_BITS-1:0] now_ms;
   } evt_type;

   // One status result.
   typedef struct packed {
      logic [CHAN_BITS-1:0]  channel;
      logic                  retune;
      logic                  locked;
      logic                  ever_valid;
      logic                  fresh;
      logic [COUNT_BITS-1:0] rx_rate;
      logic [COUNT_BITS-1:0] valid_count;
      logic [COUNT_BITS-1:0] invalid_count;
   } res_type;

endpackage

`default_nettype wire

// File: rtl/rcsl_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

// Event channel into the block.
interface rcsl_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic        req_packet_ok;
   logic [31:0] req_now_ms;

   modport source (output valid, output req_type, output req_packet_ok,
                   output req_now_ms, input ready);
   modport sink (input valid, input req_type, input req_packet_ok,
                 input req_now_ms, output ready);
endinterface

// Status result channel out of the block.
interface rcsl_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  rsp_channel;
   logic        rsp_retune;
   logic        rsp_locked;
   logic        rsp_ever_valid;
   logic        rsp_fresh;
   logic [31:0] rsp_rx_rate;
   logic [31:0] rsp_valid_count;
   logic [31:0] rsp_invalid_count;

   modport source (output valid, output rsp_channel, output rsp_retune,
                   output rsp_locked, output rsp_ever_valid, output rsp_fresh,
                   output rsp_rx_rate, output rsp_valid_count,
                   output rsp_invalid_count, input ready);
   modport sink (input valid, input rsp_channel, input rsp_retune,
                 input rsp_locked, input rsp_ever_valid, input rsp_fresh,
                 input rsp_rx_rate, input rsp_valid_count,
                 input rsp_invalid_count, output ready);
endinterface

`default_nettype wire

// File: rtl/radio_channel_scan_lock_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Radio channel scan and lock controller.
// Events (start, packet arrival, periodic tick, each stamped with a
// millisecond time) arrive on req_chan as valid/ready transfers; every event
// yields exactly one status result on rsp_chan, in order.
// Configuration registers are written through csr_wr_en, csr_index and
// csr_wr_data, one register per cycle; the user must write them only while
// no event is in flight; the block does not enforce it. An accepted event
// is held in an input register, passes once through the update logic of
// rcsl_core and lands in the result register. One event is accepted per
// cycle while results are taken; the single pass through the state update
// logic sets that rate. A stalled receiver holds the result register; the
// input register still takes one more event, and req_chan.ready falls only
// once both are full. Synchronous reset empties both registers, restores
// the register defaults and returns to scanning on channel 1 with all counts
// and times at zero. TIME_BITS sets the width of the internal millisecond
// timestamps; the event time is truncated or zero-extended to it.

module radio_channel_scan_lock_top #(
   parameter int TIME_BITS = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   rcsl_req_if.sink                                 req_chan,
   rcsl_rsp_if.source                               rsp_chan,
   input  wire logic                                csr_wr_en,
   input  wire logic [rcsl_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [rcsl_pkg::CSR_DATA_BITS-1:0]  csr_wr_data
);

   rcsl_pkg::cfg_type cfg;
   rcsl_pkg::res_type res;

   logic              s1_valid_ff, s1_valid_in;
   rcsl_pkg::evt_type s1_evt_ff, s1_evt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rcsl_pkg::res_type rsp_data_ff, rsp_data_in;

   logic              out_free;
   logic              advance;
   logic              req_fire;

   rcsl_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   rcsl_core #(
      .TIME_BITS (TIME_BITS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .evt     (s1_evt_ff),
      .cfg     (cfg),
      .res     (res)
   );

   // Handshake: the event moves on whenever the result register is free.
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign advance        = s1_valid_ff && out_free;
   assign req_chan.ready = !s1_valid_ff || out_free;
   assign req_fire       = req_chan.valid && req_chan.ready;

   // Input register.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_evt_in   = s1_evt_ff;
      if (req_fire) begin
         s1_valid_in         = 1'b1;
         s1_evt_in.req_type  = req_chan.req_type;
         s1_evt_in.packet_ok = req_chan.req_packet_ok;
         s1_evt_in.now_ms    = req_chan.req_now_ms;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   // Result register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_evt_ff   <= s1_evt_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Result channel outputs.
   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.rsp_channel       = rsp_data_ff.channel;
   assign rsp_chan.rsp_retune        = rsp_data_ff.retune;
   assign rsp_chan.rsp_locked        = rsp_data_ff.locked;
   assign rsp_chan.rsp_ever_valid    = rsp_data_ff.ever_valid;
   assign rsp_chan.rsp_fresh         = rsp_data_ff.fresh;
   assign rsp_chan.rsp_rx_rate       = rsp_data_ff.rx_rate;
   assign rsp_chan.rsp_valid_count   = rsp_data_ff.valid_count;
   assign rsp_chan.rsp_invalid_count = rsp_data_ff.invalid_count;

   // An event that cannot move on stays in the input register unchanged.
   a_s1_hold : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |=> (s1_valid_ff && $stable(s1_evt_ff)))
      else $error("held event lost or altered in the input register");

   // Every event that moves on shows up as a result in the next cycle.
   a_result_follows : assert property (@(posedge clock) disable iff (reset)
      advance |=> (rsp_valid_ff && rsp_data_ff == $past(res)))
      else $error("event passed on without its result");

   // Once lock has been reached it is never forgotten.
   a_ever_valid_sticky : assert property (@(posedge clock) disable iff (reset)
      (advance && rsp_valid_ff && rsp_data_ff.ever_valid) |-> res.ever_valid)
      else $error("ever_valid cleared after lock");

endmodule

`default_nettype wire

// File: rtl/rcsl_csr.sv
`timescale 1ns / 1ps
`default_nettype none

module rcsl_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_wr_en,
   input  wire logic [rcsl_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [rcsl_pkg::CSR_DATA_BITS-1:0]  csr_wr_data,
   output      rcsl_pkg::cfg_type                   cfg
);

   rcsl_pkg::cfg_type cfg_ff;
   rcsl_pkg::cfg_type cfg_in;

   // Decode the register index; writes beyond the list are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            rcsl_pkg::CSR_SCAN_ENABLE:    cfg_in.scan_enable = csr_wr_data[0];
            rcsl_pkg::CSR_CHAN_MIN:
               cfg_in.chan_min = csr_wr_data[rcsl_pkg::CHAN_BITS-1:0];
            rcsl_pkg::CSR_CHAN_MAX:
               cfg_in.chan_max = csr_wr_data[rcsl_pkg::CHAN_BITS-1:0];
            rcsl_pkg::CSR_LOCK_THRESHOLD:
               cfg_in.lock_threshold = csr_wr_data[rcsl_pkg::HITS_BITS-1:0];
            rcsl_pkg::CSR_DWELL_MS:       cfg_in.dwell_ms = csr_wr_data;
            rcsl_pkg::CSR_LOST_MS:        cfg_in.lost_ms  = csr_wr_data;
            rcsl_pkg::CSR_STALE_MS:       cfg_in.stale_ms = csr_wr_data;
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.scan_enable    <= 1'b1;
         cfg_ff.chan_min       <= 4'd1;
         cfg_ff.chan_max       <= 4'd13;
         cfg_ff.lock_threshold <= 8'd3;
         cfg_ff.dwell_ms       <= 16'd250;
         cfg_ff.lost_ms        <= 16'd3000;
         cfg_ff.stale_ms       <= 16'd1000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// File: rtl/rcsl_core.sv
`timescale 1ns / 1ps
`default_nettype none

module rcsl_core #(
   parameter int TIME_BITS = 32
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                advance,
   input  wire rcsl_pkg::evt_type   evt,
   input  wire rcsl_pkg::cfg_type   cfg,
   output      rcsl_pkg::res_type   res
);

   localparam int CB = rcsl_pkg::COUNT_BITS;

   // Acquisition and statistics state.
   logic                               is_locked_ff, is_locked_in;
   logic                               seen_lock_ff, seen_lock_in;
   logic [rcsl_pkg::CHAN_BITS-1:0]     cur_channel_ff, cur_channel_in;
   logic [rcsl_pkg::HITS_BITS-1:0]     channel_hits_ff, channel_hits_in;
   logic [CB-1:0]                      valid_total_ff, valid_total_in;
   logic [CB-1:0]                      invalid_total_ff, invalid_total_in;
   logic [TIME_BITS-1:0]               last_packet_time_ff, last_packet_time_in;
   logic [TIME_BITS-1:0]               last_hop_time_ff, last_hop_time_in;
   logic [TIME_BITS-1:0]               rate_window_start_ff, rate_window_start_in;
   logic [CB-1:0]                      rate_base_count_ff, rate_base_count_in;
   logic [CB-1:0]                      rate_value_ff, rate_value_in;

   logic [TIME_BITS-1:0]               now_t;
   logic [TIME_BITS-1:0]               since_window;
   logic [TIME_BITS-1:0]               since_hop;
   logic [TIME_BITS-1:0]               since_packet;
   logic [TIME_BITS-1:0]               packet_age;
   logic [rcsl_pkg::CHAN_BITS-1:0]     next_channel;
   logic                               retune;

   // Time differences, all modulo the timer width.
   assign now_t        = TIME_BITS'(evt.now_ms);
   assign since_window = now_t - rate_window_start_ff;
   assign since_hop    = now_t - last_hop_time_ff;
   assign since_packet = now_t - last_packet_time_ff;
   assign packet_age   = now_t - last_packet_time_in;

   // Next channel of the scan, wrapping from the top of the range.
   assign next_channel = (cur_channel_ff >= cfg.chan_max) ? cfg.chan_min
                                                          : cur_channel_ff + 4'd1;

   // Apply the event to the state.
   always_comb begin
      is_locked_in         = is_locked_ff;
      seen_lock_in         = seen_lock_ff;
      cur_channel_in       = cur_channel_ff;
      channel_hits_in      = channel_hits_ff;
      valid_total_in       = valid_total_ff;
      invalid_total_in     = invalid_total_ff;
      last_packet_time_in  = last_packet_time_ff;
      last_hop_time_in     = last_hop_time_ff;
      rate_window_start_in = rate_window_start_ff;
      rate_base_count_in   = rate_base_count_ff;
      rate_value_in        = rate_value_ff;
      retune               = 1'b0;

      unique case (evt.req_type)
         rcsl_pkg::EVT_START: begin
            cur_channel_in   = cfg.chan_min;
            channel_hits_in  = '0;
            last_hop_time_in = now_t;
            retune           = 1'b1;
         end
         rcsl_pkg::EVT_PACKET: begin
            if (evt.packet_ok) begin
               last_packet_time_in = now_t;
               valid_total_in      = valid_total_ff + 32'd1;
               if (channel_hits_ff != rcsl_pkg::HITS_MAX) begin
                  channel_hits_in = channel_hits_ff + 8'd1;
               end
            end else begin
               invalid_total_in = invalid_total_ff + 32'd1;
            end
         end
         rcsl_pkg::EVT_TICK: begin
            // Close the rate window once it has run its full length.
            if (since_window >= TIME_BITS'(rcsl_pkg::RATE_WINDOW_MS)) begin
               rate_value_in        = valid_total_ff - rate_base_count_ff;
               rate_base_count_in   = valid_total_ff;
               rate_window_start_in = now_t;
            end
            if (cfg.scan_enable) begin
               if (!is_locked_ff) begin
                  if (channel_hits_ff >= cfg.lock_threshold) begin
                     is_locked_in = 1'b1;
                     seen_lock_in = 1'b1;
                  end else if (since_hop >= TIME_BITS'(cfg.dwell_ms)) begin
                     last_hop_time_in = now_t;
                     cur_channel_in   = next_channel;
                     channel_hits_in  = '0;
                     retune           = 1'b1;
                  end
               end else if (since_packet >= TIME_BITS'(cfg.lost_ms)) begin
                  // Silence on a locked channel: rescan from where we are.
                  is_locked_in     = 1'b0;
                  last_hop_time_in = now_t;
                  channel_hits_in  = '0;
                  retune           = 1'b1;
               end
            end else if (!is_locked_ff &&
                         valid_total_ff >= CB'(cfg.lock_threshold)) begin
               is_locked_in = 1'b1;
               seen_lock_in = 1'b1;
            end
         end
         default: retune = 1'b0;
      endcase
   end

   // Status seen after the event.
   always_comb begin
      res.channel       = cur_channel_in;
      res.retune        = retune;
      res.locked        = is_locked_in;
      res.ever_valid    = seen_lock_in;
      res.fresh         = seen_lock_in && (packet_age <= TIME_BITS'(cfg.stale_ms));
      res.rx_rate       = rate_value_in;
      res.valid_count   = valid_total_in;
      res.invalid_count = invalid_total_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         is_locked_ff         <= 1'b0;
         seen_lock_ff         <= 1'b0;
         cur_channel_ff       <= 4'd1;
         channel_hits_ff      <= '0;
         valid_total_ff       <= '0;
         invalid_total_ff     <= '0;
         last_packet_time_ff  <= '0;
         last_hop_time_ff     <= '0;
         rate_window_start_ff <= '0;
         rate_base_count_ff   <= '0;
         rate_value_ff        <= '0;
      end else if (advance) begin
         is_locked_ff         <= is_locked_in;
         seen_lock_ff         <= seen_lock_in;
         cur_channel_ff       <= cur_channel_in;
         channel_hits_ff      <= channel_hits_in;
         valid_total_ff       <= valid_total_in;
         invalid_total_ff     <= invalid_total_in;
         last_packet_time_ff  <= last_packet_time_in;
         last_hop_time_ff     <= last_hop_time_in;
         rate_window_start_ff <= rate_window_start_in;
         rate_base_count_ff   <= rate_base_count_in;
         rate_value_ff        <= rate_value_in;
      end
   end

endmodule

`default_nettype wire

// File: tb/sv/rcsl_status_checker.sv
`timescale 1ns / 1ps

// Watches the event, status and register ports of the scan and lock block,
// keeps its own copy of the receiver state and checks every status transfer
// against the oldest status predicted from an accepted event.
module rcsl_status_checker (
   input  wire logic                                clock,
   input  wire logic                                reset,
   rcsl_req_if                                      req_mon,
   rcsl_rsp_if                                      rsp_mon,
   input  wire logic                                csr_wr_en,
   input  wire logic [rcsl_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [rcsl_pkg::CSR_DATA_BITS-1:0]  csr_wr_data,
   output int                                       fail_count,
   output int                                       pending
);
   import rcsl_pkg::*;

   localparam int PRINT_CAP = 200;

   typedef struct packed {
      logic [CHAN_BITS-1:0]  channel;
      logic                  retune;
      logic                  locked;
      logic                  ever_valid;
      logic                  fresh;
      logic [COUNT_BITS-1:0] rx_rate;
      logic [COUNT_BITS-1:0] valid_count;
      logic [COUNT_BITS-1:0] invalid_count;
   } status_type;

   // Register copy, as the block should hold it.
   cfg_type cfg;

   // Receiver state, as the block should hold it.
   logic                  is_locked_now;
   logic                  lock_seen;
   logic [CHAN_BITS-1:0]  tuned_channel;
   logic [HITS_BITS-1:0]  hit_count;
   logic [COUNT_BITS-1:0] good_total;
   logic [COUNT_BITS-1:0] bad_total;
   logic [NOW_BITS-1:0]   last_good_ms;
   logic [NOW_BITS-1:0]   last_hop_ms;
   logic [NOW_BITS-1:0]   window_start_ms;
   logic [COUNT_BITS-1:0] window_base;
   logic [COUNT_BITS-1:0] rate_now;

   // Statuses predicted but not yet seen on the result channel.
   status_type awaited_status[$];
   int         result_no;

   task automatic report_failure(input string msg);
      fail_count++;
      if (fail_count <= PRINT_CAP) begin
         $display("[%0t] %s", $time, msg);
      end
   endtask

   task automatic check_field(input string field, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         report_failure($sformatf("status %0d: %s is %0h, expected %0h",
                                  result_no, field, got, want));
      end
   endtask

   // Applies one event to the state copy and returns the status it causes.
   function automatic status_type advance_scan_state(input logic [1:0] code,
                                                     input logic ok,
                                                     input logic [NOW_BITS-1:0] now);
      status_type          st;
      logic                tuned;
      logic [NOW_BITS-1:0] since_window;
      logic [NOW_BITS-1:0] since_hop;
      logic [NOW_BITS-1:0] since_good;

      tuned = 1'b0;
      case (code)
         EVT_START: begin
            tuned_channel = cfg.chan_min;
            hit_count     = '0;
            last_hop_ms   = now;
            tuned         = 1'b1;
         end
         EVT_PACKET: begin
            if (ok) begin
               last_good_ms = now;
               good_total++;
               if (hit_count != HITS_MAX) begin
                  hit_count++;
               end
            end else begin
               bad_total++;
            end
         end
         EVT_TICK: begin
            // The rate window closes once a full window has passed.
            since_window = now - window_start_ms;
            if (since_window >= 32'(RATE_WINDOW_MS)) begin
               rate_now        = good_total - window_base;
               window_base     = good_total;
               window_start_ms = now;
            end
            since_hop  = now - last_hop_ms;
            since_good = now - last_good_ms;
            if (cfg.scan_enable) begin
               if (!is_locked_now) begin
                  // Lock on enough hits, or else hop once the dwell is over.
                  if (hit_count >= cfg.lock_threshold) begin
                     is_locked_now = 1'b1;
                     lock_seen     = 1'b1;
                  end else if (since_hop >= 32'(cfg.dwell_ms)) begin
                     last_hop_ms   = now;
                     tuned_channel = (tuned_channel >= cfg.chan_max) ? cfg.chan_min :
                                     CHAN_BITS'(tuned_channel + 1'b1);
                     hit_count     = '0;
                     tuned         = 1'b1;
                  end
               end else if (since_good >= 32'(cfg.lost_ms)) begin
                  // Silence while locked: scan again from the same channel.
                  is_locked_now = 1'b0;
                  last_hop_ms   = now;
                  hit_count     = '0;
                  tuned         = 1'b1;
               end
            end else if (!is_locked_now && good_total >= 32'(cfg.lock_threshold)) begin
               is_locked_now = 1'b1;
               lock_seen     = 1'b1;
            end
         end
         default: begin
         end
      endcase

      since_good       = now - last_good_ms;
      st.channel       = tuned_channel;
      st.retune        = tuned;
      st.locked        = is_locked_now;
      st.ever_valid    = lock_seen;
      st.fresh         = lock_seen && (since_good <= 32'(cfg.stale_ms));
      st.rx_rate       = rate_now;
      st.valid_count   = good_total;
      st.invalid_count = bad_total;
      return st;
   endfunction

   // Everything is sampled at the rising edge, before the block updates.
   always @(posedge clock) begin : watch
      status_type want;
      if (reset) begin
         cfg             = '{scan_enable: 1'b1, chan_min: 4'd1, chan_max: 4'd13,
                             lock_threshold: 8'd3, dwell_ms: 16'd250,
                             lost_ms: 16'd3000, stale_ms: 16'd1000};
         is_locked_now   = 1'b0;
         lock_seen       = 1'b0;
         tuned_channel   = 4'd1;
         hit_count       = '0;
         good_total      = '0;
         bad_total       = '0;
         last_good_ms    = '0;
         last_hop_ms     = '0;
         window_start_ms = '0;
         window_base     = '0;
         rate_now        = '0;
         awaited_status.delete();
      end else begin
         // A status transfer is compared with the oldest prediction.
         if (rsp_mon.valid && rsp_mon.ready) begin
            result_no++;
            if (awaited_status.size() == 0) begin
               report_failure($sformatf("status %0d arrived with no event outstanding",
                                        result_no));
            end else begin
               want = awaited_status.pop_front();
               check_field("channel", 32'(rsp_mon.rsp_channel), 32'(want.channel));
               check_field("retune", 32'(rsp_mon.rsp_retune), 32'(want.retune));
               check_field("locked", 32'(rsp_mon.rsp_locked), 32'(want.locked));
               check_field("ever_valid", 32'(rsp_mon.rsp_ever_valid),
                           32'(want.ever_valid));
               check_field("fresh", 32'(rsp_mon.rsp_fresh), 32'(want.fresh));
               check_field("rx_rate", rsp_mon.rsp_rx_rate, want.rx_rate);
               check_field("valid_count", rsp_mon.rsp_valid_count, want.valid_count);
               check_field("invalid_count", rsp_mon.rsp_invalid_count,
                           want.invalid_count);
            end
         end

         // An event transfer yields exactly one status.
         if (req_mon.valid && req_mon.ready) begin
            awaited_status.push_back(advance_scan_state(req_mon.req_type,
                                                        req_mon.req_packet_ok,
                                                        req_mon.req_now_ms));
         end

         // Register writes keep only the bits each register holds.
         if (csr_wr_en) begin
            case (csr_index)
               CSR_SCAN_ENABLE:    cfg.scan_enable    = csr_wr_data[0];
               CSR_CHAN_MIN:       cfg.chan_min       = csr_wr_data[CHAN_BITS-1:0];
               CSR_CHAN_MAX:       cfg.chan_max       = csr_wr_data[CHAN_BITS-1:0];
               CSR_LOCK_THRESHOLD: cfg.lock_threshold = csr_wr_data[HITS_BITS-1:0];
               CSR_DWELL_MS:       cfg.dwell_ms       = csr_wr_data[MS_BITS-1:0];
               CSR_LOST_MS:        cfg.lost_ms        = csr_wr_data[MS_BITS-1:0];
               CSR_STALE_MS:       cfg.stale_ms       = csr_wr_data[MS_BITS-1:0];
               default: begin
               end
            endcase
         end
      end
      pending = awaited_status.size();
   end

endmodule

// File: tb/sv/tb_radio_channel_scan_lock_top.sv
`timescale 1ns / 1ps

module tb_radio_channel_scan_lock_top;
   import rcsl_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   // Codes that the package does not name.
   localparam logic [1:0]                EVT_UNUSED = 2'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED = 3'd7;

   typedef enum int {PH_MIXED, PH_FLOOD} phase_kind_type;
   typedef enum int {STALL_NONE, STALL_COIN, STALL_PERIODIC, STALL_LONG} stall_kind_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_wr_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wr_data;
   int                        fail_count;
   int                        pending;
   int                        cycle_count;
   int                        burst_left;
   cfg_type                   cfg_cur;
   logic [NOW_BITS-1:0]       stamp_ms;

   rcsl_req_if req_chan ();
   rcsl_rsp_if rsp_chan ();

   radio_channel_scan_lock_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   rcsl_status_checker status_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   always #5 clock = ~clock;

   // Guard against a hung handshake.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // The receiver stalls on a pattern that is chosen anew at random times.
   initial begin : receiver
      stall_kind_type mode;
      int             left;
      int             hold;
      rsp_chan.ready = 1'b0;
      mode = STALL_NONE;
      left = 0;
      hold = 0;
      forever begin
         @(negedge clock);
         if (left == 0) begin
            mode = stall_kind_type'($urandom_range(0, 3));
            left = $urandom_range(20, 120);
         end
         left--;
         case (mode)
            STALL_NONE:     rsp_chan.ready <= 1'b1;
            STALL_COIN:     rsp_chan.ready <= 1'($urandom_range(0, 1));
            STALL_PERIODIC: rsp_chan.ready <= (left % 4 == 0);
            default: begin
               if (hold > 0) begin
                  hold--;
                  rsp_chan.ready <= 1'b0;
               end else begin
                  hold = $urandom_range(0, 8);
                  rsp_chan.ready <= 1'b1;
               end
            end
         endcase
      end
   end

   // Drives one event and holds it until its transfer; returns at a falling
   // edge with valid still high.
   task automatic send_event(input logic [1:0] code, input logic ok,
                             input logic [NOW_BITS-1:0] now);
      req_chan.valid         <= 1'b1;
      req_chan.req_type      <= code;
      req_chan.req_packet_ok <= ok;
      req_chan.req_now_ms    <= now;
      do begin
         @(posedge clock);
      end while (!req_chan.ready);
      @(negedge clock);
   endtask

   // The sender works in bursts, with idle gaps between them.
   task automatic issue_event(input logic [1:0] code, input logic ok,
                              input logic [NOW_BITS-1:0] now);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) :
                                                    $urandom_range(1, 10);
      end
      burst_left--;
      send_event(code, ok, now);
   endtask

   // Holds the sender off until every outstanding status has come back.
   task automatic wait_for_quiet();
      req_chan.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= index;
      csr_wr_data <= data;
      @(negedge clock);
   endtask

   // Writes every register; unused upper data bits carry noise.
   task automatic apply_config(input cfg_type c);
      logic [CSR_DATA_BITS-1:0] noise;
      noise = CSR_DATA_BITS'($urandom);
      write_reg(CSR_SCAN_ENABLE, {noise[15:1], c.scan_enable});
      write_reg(CSR_CHAN_MIN, {noise[15:4], c.chan_min});
      write_reg(CSR_CHAN_MAX, {noise[11:0], c.chan_max});
      write_reg(CSR_LOCK_THRESHOLD, {noise[7:0], c.lock_threshold});
      write_reg(CSR_DWELL_MS, c.dwell_ms);
      write_reg(CSR_LOST_MS, c.lost_ms);
      write_reg(CSR_STALE_MS, c.stale_ms);
      write_reg(CSR_UNUSED, noise);
      csr_wr_en <= 1'b0;
      @(negedge clock);
      cfg_cur = c;
   endtask

   // Time steps are scaled to the current dwell and silence limits.
   function automatic logic [NOW_BITS-1:0] pick_step();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 35) return $urandom_range(0, 40);
      if (r < 75) return $urandom_range(0, 2 * int'(cfg_cur.dwell_ms) + 10);
      if (r < 95) return $urandom_range(0, int'(cfg_cur.lost_ms) + int'(cfg_cur.stale_ms) + 100);
      return $urandom;
   endfunction

   task automatic run_phase(input int count, input phase_kind_type kind);
      int          r;
      logic [1:0]  code;
      logic        ok;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (kind == PH_FLOOD) begin
            // Long stay on one channel so that the hit count saturates.
            code = (n == 0) ? EVT_START : (r < 96) ? EVT_PACKET : EVT_TICK;
            ok   = ($urandom_range(0, 99) < 97);
            stamp_ms += $urandom_range(0, 2);
         end else begin
            code = (r < 6) ? EVT_START : (r < 52) ? EVT_PACKET :
                   (r < 95) ? EVT_TICK : EVT_UNUSED;
            ok   = (code == EVT_PACKET) ? ($urandom_range(0, 99) < 85) :
                                          1'($urandom_range(0, 1));
            if ($urandom_range(0, 49) == 0) begin
               stamp_ms = 32'hFFFF_F000 + $urandom_range(0, 4095);
            end else begin
               stamp_ms += pick_step();
            end
         end
         if ($urandom_range(0, 59) == 0) begin
            wait_for_quiet();
         end
         issue_event(code, ok, stamp_ms);
      end
   endtask

   initial begin : stimulus
      cfg_type c;
      req_chan.valid         = 1'b0;
      req_chan.req_type      = EVT_START;
      req_chan.req_packet_ok = 1'b0;
      req_chan.req_now_ms    = '0;
      csr_wr_en              = 1'b0;
      csr_index              = CSR_SCAN_ENABLE;
      csr_wr_data            = '0;
      burst_left             = 0;
      cfg_cur = '{scan_enable: 1'b1, chan_min: 4'd1, chan_max: 4'd13,
                  lock_threshold: 8'd3, dwell_ms: 16'd250,
                  lost_ms: 16'd3000, stale_ms: 16'd1000};

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed walk through the defaults: lock, rate window, start while
      // locked, loss of lock, a hop, time wrap and the unused event code.
      issue_event(EVT_UNUSED, 1'b1, 32'd0);
      issue_event(EVT_TICK, 1'b0, 32'd0);
      issue_event(EVT_START, 1'b1, 32'd100);
      issue_event(EVT_PACKET, 1'b1, 32'd110);
      issue_event(EVT_PACKET, 1'b0, 32'd115);
      issue_event(EVT_PACKET, 1'b1, 32'd120);
      issue_event(EVT_TICK, 1'b1, 32'd125);
      issue_event(EVT_PACKET, 1'b1, 32'd130);
      issue_event(EVT_TICK, 1'b0, 32'd140);
      issue_event(EVT_TICK, 1'b0, 32'd1200);
      issue_event(EVT_PACKET, 1'b1, 32'd1250);
      issue_event(EVT_TICK, 1'b0, 32'd1300);
      issue_event(EVT_START, 1'b0, 32'd1400);
      issue_event(EVT_TICK, 1'b0, 32'd4250);
      issue_event(EVT_TICK, 1'b1, 32'd4500);
      issue_event(EVT_PACKET, 1'b1, 32'hFFFF_FFFF);
      issue_event(EVT_TICK, 1'b1, 32'h0000_0005);
      issue_event(EVT_UNUSED, 1'b0, 32'h8000_0000);
      issue_event(EVT_PACKET, 1'b0, 32'h8000_0001);
      issue_event(EVT_TICK, 1'b1, 32'hFFFF_FFFE);
      wait_for_quiet();

      stamp_ms = $urandom;

      // Lowest settings everywhere.
      apply_config('{scan_enable: 1'b1, chan_min: 4'd1, chan_max: 4'd1,
                     lock_threshold: 8'd1, dwell_ms: 16'd1, lost_ms: 16'd1,
                     stale_ms: 16'd0});
      run_phase(35, PH_MIXED);
      wait_for_quiet();

      // Scanning off: lock on the running total, no rescan on silence.
      apply_config('{scan_enable: 1'b0, chan_min: 4'd5, chan_max: 4'd9,
                     lock_threshold: 8'd4, dwell_ms: 16'd300, lost_ms: 16'd2000,
                     stale_ms: 16'd500});
      run_phase(35, PH_MIXED);
      wait_for_quiet();

      // Highest threshold and time limits; the flood saturates the hit count.
      apply_config('{scan_enable: 1'b1, chan_min: 4'd14, chan_max: 4'd14,
                     lock_threshold: 8'd255, dwell_ms: 16'hFFFF, lost_ms: 16'hFFFF,
                     stale_ms: 16'hFFFF});
      run_phase(320, PH_FLOOD);
      wait_for_quiet();

      // Zero threshold and dwell, channel limits outside the band.
      apply_config('{scan_enable: 1'b1, chan_min: 4'd0, chan_max: 4'd15,
                     lock_threshold: 8'd0, dwell_ms: 16'd0, lost_ms: 16'd100,
                     stale_ms: 16'd50});
      run_phase(35, PH_MIXED);
      wait_for_quiet();

      // Lowest channel above the highest.
      apply_config('{scan_enable: 1'b1, chan_min: 4'd10, chan_max: 4'd3,
                     lock_threshold: 8'd2, dwell_ms: 16'd80, lost_ms: 16'd600,
                     stale_ms: 16'd200});
      run_phase(35, PH_MIXED);
      wait_for_quiet();

      // A random setting.
      c.scan_enable    = 1'($urandom_range(0, 1));
      c.chan_min       = 4'($urandom_range(0, 15));
      c.chan_max       = 4'($urandom_range(0, 15));
      c.lock_threshold = 8'($urandom_range(0, 8));
      c.dwell_ms       = 16'($urandom_range(0, 400));
      c.lost_ms        = 16'($urandom_range(1, 4000));
      c.stale_ms       = 16'($urandom_range(0, 2000));
      apply_config(c);
      run_phase(35, PH_MIXED);
      wait_for_quiet();

      // Back to the reset values.
      apply_config('{scan_enable: 1'b1, chan_min: 4'd1, chan_max: 4'd13,
                     lock_threshold: 8'd3, dwell_ms: 16'd250, lost_ms: 16'd3000,
                     stale_ms: 16'd1000});
      run_phase(35, PH_MIXED);

      // Let the last statuses drain, then a short settling time.
      wait_for_quiet();
      repeat (10) @(negedge clock);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
